// File: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on clk, off while in reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, off while in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/vts_pkg.sv
// types, constants and helpers of the trilinear volume sampler
`timescale 1ns / 1ps
`default_nettype none

package vts_pkg;

    localparam int unsigned MAX_DIM_DEF = 64;
    localparam int unsigned WFB_DEF     = 16;

    localparam int SIZE_W    = 7;
    localparam int VIDX_W    = 6;
    localparam int HU_W      = 13;
    localparam int CODE_W    = 12;
    localparam int POS_W     = 18;
    localparam int POS_FRAC  = 16;
    localparam int Q8_W      = 21;
    localparam int DIFF_W    = 22;
    localparam int LAT_W     = 10;
    localparam int CFG_IDX_W = 2;

    localparam int HU_OUTSIDE = -1024;
    localparam int HU_MAX     = 3071;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef logic signed [Q8_W-1:0] q8_t;

    localparam q8_t OUTSIDE_Q8 = Q8_W'(HU_OUTSIDE * 256);

    // clamp to the ct range and store with an offset of 1024
    function automatic logic [CODE_W-1:0] sat_code(input logic signed [HU_W-1:0] v);
        logic [CODE_W-1:0] c;
        if (v < -13'sd1024)
        begin
            c = '0;
        end
        else if (v > 13'sd3071)
        begin
            c = '1;
        end
        else
        begin
            c = CODE_W'(v + 13'sd1024);
        end
        return c;
    endfunction

    // stored code back to hu, then to 8 fraction bits
    function automatic q8_t code_to_q8(input logic [CODE_W-1:0] code);
        logic signed [HU_W-1:0] hu;
        hu = signed'({1'b0, code}) - 13'sd1024;
        return q8_t'({hu, 8'b0});
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/volume_trilinear_sampler.sv
// volume store and trilinear sampler around one shared multiplier
// write word: item_ready stays high, no result
// sample word: item_ready stays low until the done state registers the result, which can wait
//   on result_ready; the work is 3 axis scalings and 7 lerps through one multiplier, plus
//   8 reads of the single-port voxel store
// reset clears control and sets all sizes to 64; store contents are undefined until written
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module volume_trilinear_sampler
    import vts_pkg::*;
#(
    parameter int unsigned MAX_DIM          = MAX_DIM_DEF,
    parameter int unsigned WEIGHT_FRAC_BITS = WFB_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        cfg_valid,
    output      logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [SIZE_W-1:0]           cfg_data,

    input  wire logic                        item_valid,
    output      logic                        item_ready,
    input  wire logic                        kind,
    input  wire logic [VIDX_W-1:0]           voxel_x,
    input  wire logic [VIDX_W-1:0]           voxel_y,
    input  wire logic [VIDX_W-1:0]           voxel_z,
    input  wire logic signed [HU_W-1:0]      voxel_value,
    input  wire logic signed [POS_W-1:0]     pos_x,
    input  wire logic signed [POS_W-1:0]     pos_y,
    input  wire logic signed [POS_W-1:0]     pos_z,

    output      logic                        result_valid,
    input  wire logic                        result_ready,
    output      logic signed [Q8_W-1:0]      intensity
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = 3 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int W      = WEIGHT_FRAC_BITS;
    localparam int MB_W   = W + 1;
    localparam int PROD_W = DIFF_W + MB_W;
    localparam int UP     = (W >= POS_FRAC) ? W - POS_FRAC : 0;
    localparam int DN     = (W < POS_FRAC) ? POS_FRAC - W : 0;
    localparam int HALF   = 1 << (W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_FETCH,
        ST_LERP,
        ST_DONE
    } state_t;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
        logic [SIZE_W-1:0] s;
        if (r < SIZE_W'(2))
        begin
            s = SIZE_W'(2);
        end
        else if (32'(r) > MAX_DIM)
        begin
            s = SIZE_W'(MAX_DIM);
        end
        else
        begin
            s = r;
        end
        return s;
    endfunction

    state_t                      state_reg, state_next;
    logic [3:0]                  step_reg, step_next;
    logic                        lph_reg, lph_next;
    logic [SIZE_W-1:0]           size_x_reg, size_x_next;
    logic [SIZE_W-1:0]           size_y_reg, size_y_next;
    logic [SIZE_W-1:0]           size_z_reg, size_z_next;
    logic signed [POS_W-1:0]     pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0]     pos_y_reg, pos_y_next;
    logic signed [POS_W-1:0]     pos_z_reg, pos_z_next;
    logic signed [LAT_W-1:0]     lat_x_reg, lat_x_next;
    logic signed [LAT_W-1:0]     lat_y_reg, lat_y_next;
    logic signed [LAT_W-1:0]     lat_z_reg, lat_z_next;
    logic [W-1:0]                wx_reg, wx_next;
    logic [W-1:0]                wy_reg, wy_next;
    logic [W-1:0]                wz_reg, wz_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    q8_t                         acc_a_reg, acc_a_next;
    q8_t                         val_reg [8];
    q8_t                         val_next [8];
    logic                        rd_out_reg, rd_out_next;
    logic                        result_valid_reg, result_valid_next;
    q8_t                         intensity_reg, intensity_next;

    logic [CODE_W-1:0]           mem [DEPTH];
    logic [CODE_W-1:0]           rdata_reg;
    logic [ADDR_W-1:0]           mem_addr;
    logic                        mem_we;
    logic [CODE_W-1:0]           wdata;

    logic [SIZE_W-1:0]           eff_x, eff_y, eff_z;
    logic signed [DIFF_W-1:0]    mult_a;
    logic signed [MB_W-1:0]      mult_b;
    logic signed [PROD_W-1:0]    mult_out;

    logic                        item_acc;
    logic                        wr_ok;
    logic [ADDR_W-1:0]           wr_addr;
    logic [ADDR_W-1:0]           rd_addr;
    logic signed [LAT_W-1:0]     cx, cy, cz;
    logic                        outside;
    logic [2:0]                  corner;
    logic signed [POS_W-1:0]     pos_sel;
    logic [SIZE_W-1:0]           size_sel;
    logic [POS_FRAC-1:0]         frac;
    logic [W-1:0]                wgt;
    logic signed [LAT_W-1:0]     lat;
    logic [W-1:0]                w_sel;
    logic signed [PROD_W-1:0]    rnd;
    logic signed [DIFF_W-1:0]    lerp_sum;

    assign cfg_ready    = 1'b1;
    assign item_ready   = (state_reg == ST_IDLE);
    assign item_acc     = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign intensity    = intensity_reg;

    assign eff_x = eff_size(size_x_reg);
    assign eff_y = eff_size(size_y_reg);
    assign eff_z = eff_size(size_z_reg);

    assign wr_ok   = (32'(voxel_x) < MAX_DIM) && (32'(voxel_y) < MAX_DIM)
                     && (32'(voxel_z) < MAX_DIM);
    assign wr_addr = {IDX_W'(voxel_z), IDX_W'(voxel_y), IDX_W'(voxel_x)};
    assign wdata   = sat_code(voxel_value);

    // corner bits: [0] x, [1] y, [2] z
    assign corner  = step_reg[2:0];
    assign cx      = lat_x_reg + $signed({{(LAT_W-1){1'b0}}, corner[0]});
    assign cy      = lat_y_reg + $signed({{(LAT_W-1){1'b0}}, corner[1]});
    assign cz      = lat_z_reg + $signed({{(LAT_W-1){1'b0}}, corner[2]});
    assign outside = (cx < 0) || (cy < 0) || (cz < 0)
                     || (cx >= $signed(LAT_W'(eff_x)))
                     || (cy >= $signed(LAT_W'(eff_y)))
                     || (cz >= $signed(LAT_W'(eff_z)));
    assign rd_addr = {IDX_W'(cz), IDX_W'(cy), IDX_W'(cx)};

    // scaled coordinate split into floor index and fraction
    assign lat  = $signed(prod_reg[POS_FRAC +: LAT_W]);
    assign frac = prod_reg[POS_FRAC-1:0];
    assign wgt  = W'((32'(frac) << UP) >> DN);

    // the shared multiplier
    assign mult_out = PROD_W'(mult_a) * PROD_W'(mult_b);

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        lph_next          = lph_reg;
        size_x_next       = size_x_reg;
        size_y_next       = size_y_reg;
        size_z_next       = size_z_reg;
        pos_x_next        = pos_x_reg;
        pos_y_next        = pos_y_reg;
        pos_z_next        = pos_z_reg;
        lat_x_next        = lat_x_reg;
        lat_y_next        = lat_y_reg;
        lat_z_next        = lat_z_reg;
        wx_next           = wx_reg;
        wy_next           = wy_reg;
        wz_next           = wz_reg;
        prod_next         = prod_reg;
        acc_a_next        = acc_a_reg;
        val_next          = val_reg;
        rd_out_next       = rd_out_reg;
        result_valid_next = result_valid_reg;
        intensity_next    = intensity_reg;
        mem_we            = 1'b0;
        mem_addr          = wr_addr;
        mult_a            = '0;
        mult_b            = '0;
        pos_sel           = pos_x_reg;
        size_sel          = eff_x;
        w_sel             = wx_reg;
        rnd               = '0;
        lerp_sum          = '0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SIZE_X: size_x_next = cfg_data;
                CFG_SIZE_Y: size_y_next = cfg_data;
                CFG_SIZE_Z: size_z_next = cfg_data;
                default:    ;
            endcase
        end

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    if (kind == KIND_SAMPLE)
                    begin
                        pos_x_next = pos_x;
                        pos_y_next = pos_y;
                        pos_z_next = pos_z;
                        step_next  = '0;
                        state_next = ST_SCALE;
                    end
                    else
                    begin
                        mem_we = wr_ok;
                    end
                end
            end

            ST_SCALE:
            begin
                case (step_reg[1:0])
                    2'd0:
                    begin
                        pos_sel  = pos_x_reg;
                        size_sel = eff_x;
                    end
                    2'd1:
                    begin
                        pos_sel  = pos_y_reg;
                        size_sel = eff_y;
                    end
                    default:
                    begin
                        pos_sel  = pos_z_reg;
                        size_sel = eff_z;
                    end
                endcase
                mult_a = DIFF_W'(pos_sel);
                mult_b = MB_W'(size_sel - SIZE_W'(1));
                if (step_reg[1:0] != 2'd3)
                begin
                    prod_next = mult_out;
                end
                // product of the previous step is split here
                case (step_reg[1:0])
                    2'd1:
                    begin
                        lat_x_next = lat;
                        wx_next    = wgt;
                    end
                    2'd2:
                    begin
                        lat_y_next = lat;
                        wy_next    = wgt;
                    end
                    2'd3:
                    begin
                        lat_z_next = lat;
                        wz_next    = wgt;
                    end
                    default: ;
                endcase
                if (step_reg[1:0] == 2'd3)
                begin
                    step_next  = '0;
                    state_next = ST_FETCH;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end

            ST_FETCH:
            begin
                if (!step_reg[3])
                begin
                    mem_addr    = rd_addr;
                    rd_out_next = outside;
                end
                // read data lags the address by the store's read register
                if (step_reg != '0)
                begin
                    for (int i = 0; i < 7; i++)
                    begin
                        val_next[i] = val_reg[i+1];
                    end
                    val_next[7] = rd_out_reg ? OUTSIDE_Q8 : code_to_q8(rdata_reg);
                end
                if (step_reg == 4'd8)
                begin
                    step_next  = '0;
                    lph_next   = 1'b0;
                    state_next = ST_LERP;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end

            ST_LERP:
            begin
                if (step_reg < 4'd4)
                begin
                    w_sel = wx_reg;
                end
                else if (step_reg < 4'd6)
                begin
                    w_sel = wy_reg;
                end
                else
                begin
                    w_sel = wz_reg;
                end
                if (!lph_reg)
                begin
                    // a + (b - a) * w, rounded half up
                    mult_a     = DIFF_W'(val_reg[1]) - DIFF_W'(val_reg[0]);
                    mult_b     = MB_W'(w_sel);
                    prod_next  = mult_out;
                    acc_a_next = val_reg[0];
                    lph_next   = 1'b1;
                end
                else
                begin
                    rnd      = prod_reg + PROD_W'(HALF);
                    lerp_sum = DIFF_W'(acc_a_reg) + DIFF_W'(rnd >>> W);
                    // queue: drop the two operands, append the result at its tail
                    for (int i = 0; i < 6; i++)
                    begin
                        val_next[i] = val_reg[i+2];
                    end
                    val_next[3'(3'd6 - step_reg[2:0])] = Q8_W'(lerp_sum);
                    lph_next = 1'b0;
                    if (step_reg == 4'd6)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        step_next = step_reg + 4'd1;
                    end
                end
            end

            ST_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    intensity_next    = val_reg[0];
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            lph_reg          <= 1'b0;
            size_x_reg       <= SIZE_RESET;
            size_y_reg       <= SIZE_RESET;
            size_z_reg       <= SIZE_RESET;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            pos_z_reg        <= '0;
            lat_x_reg        <= '0;
            lat_y_reg        <= '0;
            lat_z_reg        <= '0;
            wx_reg           <= '0;
            wy_reg           <= '0;
            wz_reg           <= '0;
            prod_reg         <= '0;
            acc_a_reg        <= '0;
            for (int i = 0; i < 8; i++)
            begin
                val_reg[i] <= '0;
            end
            rd_out_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
            intensity_reg    <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            lph_reg          <= lph_next;
            size_x_reg       <= size_x_next;
            size_y_reg       <= size_y_next;
            size_z_reg       <= size_z_next;
            pos_x_reg        <= pos_x_next;
            pos_y_reg        <= pos_y_next;
            pos_z_reg        <= pos_z_next;
            lat_x_reg        <= lat_x_next;
            lat_y_reg        <= lat_y_next;
            lat_z_reg        <= lat_z_next;
            wx_reg           <= wx_next;
            wy_reg           <= wy_next;
            wz_reg           <= wz_next;
            prod_reg         <= prod_next;
            acc_a_reg        <= acc_a_next;
            val_reg          <= val_next;
            rd_out_reg       <= rd_out_next;
            result_valid_reg <= result_valid_next;
            intensity_reg    <= intensity_next;
        end
    end

    // single-port voxel store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    `ASSERT_NEXT(a_sample_starts, item_acc && kind == KIND_SAMPLE, state_reg == ST_SCALE && !item_ready, "sample word did not start the scaling pass")
    `ASSERT_NEXT(a_fetch_to_lerp, state_reg == ST_FETCH && step_reg == 4'd8, state_reg == ST_LERP && step_reg == 4'd0 && !lph_reg, "lerp pass did not start clean after the eighth read")
    `ASSERT_IMPLIES(a_result_from_done, $rose(result_valid_reg), $past(state_reg) == ST_DONE, "result raised outside the done state")
    `ASSERT_IMPLIES(a_store_write_src, mem_we, item_acc && kind == KIND_WRITE, "store written without an accepted write word")

endmodule

`default_nettype wire
